>>> hw/rtl/tlex_pkg.sv
// Shared types, constants and word tables of the tiny language lexer.
package tlex_pkg;

  localparam int unsigned RESERVED_COUNT = 8;
  localparam int unsigned PREFIX_CHARS   = 6;
  localparam int unsigned PREFIX_W       = 8 * PREFIX_CHARS;
  localparam int unsigned LENGTH_W       = 8;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned Q_PTR_W        = 2;
  localparam int unsigned Q_LVL_W        = 3;

  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [3:0] {
    CLS_IDENT    = 4'd0,
    CLS_RESERVED = 4'd1,
    CLS_NUMBER   = 4'd2,
    CLS_PLUS     = 4'd3,
    CLS_MINUS    = 4'd4,
    CLS_MUL      = 4'd5,
    CLS_DIV      = 4'd6,
    CLS_EQ       = 4'd7,
    CLS_LT       = 4'd8,
    CLS_GT       = 4'd9,
    CLS_LPAREN   = 4'd10,
    CLS_RPAREN   = 4'd11,
    CLS_SEMI     = 4'd12,
    CLS_ASSIGN   = 4'd13
  } tok_class_e;

  typedef struct packed {
    tok_class_e            cls;
    logic [LENGTH_W-1:0]   length;
    logic [VALUE_W-1:0]    value;
    logic                  overflowed;
    logic                  last;
  } token_t;

  // Words produced by one accepted byte, first in stream order.
  typedef struct packed {
    logic [1:0] num;
    token_t     tok0;
    token_t     tok1;
  } emit_t;

  typedef struct packed {
    logic [Q_LVL_W-1:0] level;
    logic               room;
  } fifo_stat_t;

  // Reserved words, right aligned, first character in the highest byte.
  function automatic logic [PREFIX_W-1:0] word_code(input logic [2:0] idx);
    logic [PREFIX_W-1:0] code;
    unique case (idx)
      3'd0:    code = 48'h0000_0000_6966;     // if
      3'd1:    code = 48'h0000_7468_656E;     // then
      3'd2:    code = 48'h0000_656C_7365;     // else
      3'd3:    code = 48'h0000_0065_6E64;     // end
      3'd4:    code = 48'h7265_7065_6174;     // repeat
      3'd5:    code = 48'h0075_6E74_696C;     // until
      3'd6:    code = 48'h0000_7265_6164;     // read
      default: code = 48'h0077_7269_7465;     // write
    endcase
    return code;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] idx);
    logic [2:0] len;
    unique case (idx)
      3'd0:    len = 3'd2;
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd6;
      3'd5:    len = 3'd5;
      3'd6:    len = 3'd4;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/tlex_if.sv
// Byte input and token output channels of the lexer.
interface tlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       flush;

  modport source (output valid, output ch, output flush, input ready);
  modport sink   (input valid, input ch, input flush, output ready);
endinterface

interface tlex_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_class;
  logic [7:0]  token_length;
  logic [31:0] token_value;
  logic        overflowed;
  logic        last;

  modport source (output valid, output token_class, output token_length,
                  output token_value, output overflowed, output last, input ready);
  modport sink   (input valid, input token_class, input token_length,
                  input token_value, input overflowed, input last, output ready);
endinterface

>>> hw/rtl/tlex_core.sv
// Scanner state and per-byte token decision.
module tlex_core #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     ch_i,
  input  logic           flush_i,
  output tlex_pkg::emit_t emit_o
);
  import tlex_pkg::*;

  localparam int unsigned LenLim = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam int unsigned CntW   = $clog2(LenLim + 1);
  localparam int unsigned ValW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [CntW-1:0] LenMax    = CntW'(LenLim);
  localparam logic [CntW-1:0] PrefixLen = CntW'(PREFIX_CHARS);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_COLON   = 3'd4
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [PREFIX_W-1:0] prefix_q, prefix_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ValW-1:0]     value_q, value_d;
  logic                sat_q, sat_d;

  logic       is_letter, is_digit;
  logic       rsv_hit;
  logic [2:0] rsv_idx;
  token_t     pend_tok, op_tok;
  tok_class_e op_cls;
  logic       op_ok;

  logic                do_count, do_digit, restart;
  logic [PREFIX_W-1:0] base_pre;
  logic [CntW-1:0]     base_cnt;
  logic [ValW-1:0]     base_val;
  logic                base_sat, cc_ok;
  logic [ValW+3:0]     prod;
  logic                prod_ovf;
  logic                emit_pend, emit_op, emit_asg;

  always_comb begin
    is_letter = ((ch_i >= CH_LO_A) && (ch_i <= CH_LO_Z)) ||
                ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_Z));
    is_digit  = (ch_i >= CH_0) && (ch_i <= CH_9);
  end

  // Reserved word lookup on the held prefix.
  always_comb begin
    rsv_hit = 1'b0;
    rsv_idx = '0;
    for (int i = 0; i < RESERVED_COUNT; i++) begin
      if (!rsv_hit && (CntW'(word_len(3'(i))) == count_q) &&
          (word_code(3'(i)) == prefix_q)) begin
        rsv_hit = 1'b1;
        rsv_idx = 3'(i);
      end
    end
    if ((count_q > PrefixLen) || sat_q) rsv_hit = 1'b0;
  end

  always_comb begin
    pend_tok = '0;
    if (mode_q == MODE_NUMBER) begin
      pend_tok.cls        = CLS_NUMBER;
      pend_tok.length     = LENGTH_W'(count_q);
      pend_tok.value      = VALUE_W'(value_q);
      pend_tok.overflowed = sat_q;
    end else if (rsv_hit) begin
      pend_tok.cls    = CLS_RESERVED;
      pend_tok.length = LENGTH_W'(count_q);
      pend_tok.value  = VALUE_W'(rsv_idx);
    end else begin
      pend_tok.cls        = CLS_IDENT;
      pend_tok.length     = LENGTH_W'(count_q);
      pend_tok.overflowed = sat_q;
    end
  end

  always_comb begin
    op_ok  = 1'b1;
    op_cls = CLS_IDENT;
    unique case (ch_i)
      CH_PLUS:   op_cls = CLS_PLUS;
      CH_MINUS:  op_cls = CLS_MINUS;
      CH_STAR:   op_cls = CLS_MUL;
      CH_SLASH:  op_cls = CLS_DIV;
      CH_EQ:     op_cls = CLS_EQ;
      CH_LT:     op_cls = CLS_LT;
      CH_GT:     op_cls = CLS_GT;
      CH_LPAREN: op_cls = CLS_LPAREN;
      CH_RPAREN: op_cls = CLS_RPAREN;
      CH_SEMI:   op_cls = CLS_SEMI;
      default:   op_ok  = 1'b0;
    endcase
  end

  // Decide path, then run the shared count and digit update on the base state.
  always_comb begin
    mode_d    = mode_q;
    do_count  = 1'b0;
    do_digit  = 1'b0;
    restart   = 1'b0;
    emit_pend = 1'b0;
    emit_op   = 1'b0;
    emit_asg  = 1'b0;
    priority if (flush_i) begin
      emit_pend = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
      restart   = 1'b1;
      mode_d    = MODE_IDLE;
    end else if (mode_q == MODE_COMMENT) begin
      if (ch_i == CH_RBRACE) mode_d = MODE_IDLE;
    end else if ((mode_q == MODE_COLON) && (ch_i == CH_EQ)) begin
      emit_asg = 1'b1;
      mode_d   = MODE_IDLE;
    end else if ((mode_q == MODE_IDENT) && (is_letter || is_digit)) begin
      do_count = 1'b1;
    end else if ((mode_q == MODE_NUMBER) && is_digit) begin
      do_count = 1'b1;
      do_digit = 1'b1;
    end else begin
      emit_pend = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
      restart   = 1'b1;
      mode_d    = MODE_IDLE;
      if (is_letter) begin
        mode_d   = MODE_IDENT;
        do_count = 1'b1;
      end else if (is_digit) begin
        mode_d   = MODE_NUMBER;
        do_count = 1'b1;
        do_digit = 1'b1;
      end else if (ch_i == CH_LBRACE) begin
        mode_d = MODE_COMMENT;
      end else if (ch_i == CH_COLON) begin
        mode_d = MODE_COLON;
      end else begin
        emit_op = op_ok;
      end
    end

    base_pre = restart ? '0 : prefix_q;
    base_cnt = restart ? '0 : count_q;
    base_val = restart ? '0 : value_q;
    base_sat = restart ? 1'b0 : sat_q;

    cc_ok    = base_cnt < LenMax;
    prod     = ((ValW+4)'(base_val) << 3) + ((ValW+4)'(base_val) << 1) +
               (ValW+4)'(ch_i[3:0]);
    prod_ovf = |prod[ValW+3:ValW];

    prefix_d = base_pre;
    count_d  = base_cnt;
    value_d  = base_val;
    sat_d    = base_sat;
    if (do_count) begin
      if (cc_ok) begin
        count_d = base_cnt + 1'b1;
        if (base_cnt < PrefixLen) prefix_d = {base_pre[PREFIX_W-9:0], ch_i};
      end else begin
        sat_d = 1'b1;
      end
    end
    if (do_digit) begin
      if (prod_ovf) begin
        value_d = '1;
        sat_d   = 1'b1;
      end else begin
        value_d = prod[ValW-1:0];
      end
    end
  end

  always_comb begin
    op_tok        = '0;
    op_tok.cls    = emit_asg ? CLS_ASSIGN : op_cls;
    op_tok.length = emit_asg ? LENGTH_W'(2) : LENGTH_W'(1);
    emit_o        = '0;
    if (fire_i) begin
      if (emit_pend && emit_op) begin
        emit_o.num       = 2'd2;
        emit_o.tok0      = pend_tok;
        emit_o.tok1      = op_tok;
        emit_o.tok1.last = 1'b1;
      end else if (emit_pend) begin
        emit_o.num       = 2'd1;
        emit_o.tok0      = pend_tok;
        emit_o.tok0.last = 1'b1;
      end else if (emit_op || emit_asg) begin
        emit_o.num       = 2'd1;
        emit_o.tok0      = op_tok;
        emit_o.tok0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      prefix_q <= '0;
      count_q  <= '0;
      value_q  <= '0;
      sat_q    <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      prefix_q <= prefix_d;
      count_q  <= count_d;
      value_q  <= value_d;
      sat_q    <= sat_d;
    end
  end

endmodule

>>> hw/rtl/tlex_fifo.sv
// Four-word token queue: takes up to two words per cycle, gives one.
module tlex_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlex_pkg::emit_t      push_i,
  input  logic                 pop_i,
  output tlex_pkg::token_t     head_o,
  output tlex_pkg::fifo_stat_t stat_o
);
  import tlex_pkg::*;

  token_t             slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_LVL_W-1:0] level_q;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) slot_q[wr_q] <= push_i.tok0;
    if (push_i.num == 2'd2) slot_q[wr_q + 1'b1] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + Q_PTR_W'(push_i.num);
      rd_q    <= rd_q + Q_PTR_W'(pop_i);
      level_q <= level_q + Q_LVL_W'(push_i.num) - Q_LVL_W'(pop_i);
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.level = level_q;
  // Keep space for the worst case of two words from the next byte.
  assign stat_o.room  = level_q <= Q_LVL_W'(Q_DEPTH - 2);

endmodule

>>> hw/rtl/tiny_language_lexer.sv
// Top level of the tiny language lexer.
//
// Takes one source byte (or a flush) per word on in_i and emits identifier,
// reserved word, number, operator and assign tokens on out_o; comments in
// braces are skipped. A byte is accepted every cycle while the four-word
// token queue holds at most two words, so that the two tokens one byte can
// close (a pending token and an operator) always fit. A token enters the
// queue when the byte that completes it is accepted and is on out_o the
// cycle after that if the queue was empty; tokens leave in order, one per
// cycle while out_o is ready, so the sustained rate is one byte per cycle as
// long as the consumer keeps up with the token stream. Number values
// saturate at 2^min(VALUE_BITS,32)-1, lengths at min(MAX_TOKEN_LEN,255).
module tiny_language_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned VALUE_BITS    = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  tlex_in_if.sink     in_i,
  tlex_out_if.source  out_o
);
  import tlex_pkg::*;

  logic       in_fire, out_fire;
  emit_t      emit;
  token_t     head;
  fifo_stat_t stat;

  assign in_i.ready = stat.room;
  assign in_fire    = in_i.valid && stat.room;
  assign out_fire   = out_o.valid && out_o.ready;

  tlex_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .VALUE_BITS   (VALUE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .ch_i   (in_i.ch),
    .flush_i(in_i.flush),
    .emit_o (emit)
  );

  tlex_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(emit),
    .pop_i (out_fire),
    .head_o(head),
    .stat_o(stat)
  );

  assign out_o.valid        = stat.level != '0;
  assign out_o.token_class  = head.cls;
  assign out_o.token_length = head.length;
  assign out_o.token_value  = head.value;
  assign out_o.overflowed   = head.overflowed;
  assign out_o.last         = head.last;

  a_emit_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.num != 2'd0 |-> in_fire)
    else $error("tokens produced without an accepted byte");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.level <= Q_LVL_W'(Q_DEPTH))
    else $error("token queue overfilled");

  a_emit_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.num != 2'd0 |=> out_o.valid)
    else $error("emitted token not presented");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty queue");

endmodule

>>> sim/tb_top.sv
// Testbench for the tiny language lexer: byte driver, token monitor and scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import tlex_pkg::*;

  localparam int unsigned RAND_ITEMS = 2000;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_AT    = 700;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_CYC  = 20;
  localparam logic [31:0] VALUE_MAX  = 32'hFFFF_FFFF;
  localparam logic [7:0]  LEN_MAX    = 8'd255;

  typedef enum logic [2:0] {
    LX_IDLE    = 3'd0,
    LX_IDENT   = 3'd1,
    LX_NUMBER  = 3'd2,
    LX_COMMENT = 3'd3,
    LX_COLON   = 3'd4
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       flush;
  } src_byte_t;

  logic clk_i;
  logic rst_ni;

  tlex_in_if  in_if ();
  tlex_out_if out_if ();

  tiny_language_lexer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  src_byte_t   byte_q[$];
  token_t      token_q[$];
  token_t      step_toks[$];
  int unsigned bytes_taken;
  int unsigned total_bytes;
  int unsigned mismatches;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned idle_cyc;

  // scanner copy
  lex_mode_e   lx_mode;
  logic [47:0] lx_prefix;
  logic [7:0]  lx_count;
  logic [63:0] lx_value;
  logic        lx_sat;

  string kw_text [0:7] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
  string op_chars = "+-*/=<>();";

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit op_class(input logic [7:0] c, output tok_class_e cls);
    bit hit;
    hit = 1'b1;
    cls = CLS_IDENT;
    case (c)
      CH_PLUS:   cls = CLS_PLUS;
      CH_MINUS:  cls = CLS_MINUS;
      CH_STAR:   cls = CLS_MUL;
      CH_SLASH:  cls = CLS_DIV;
      CH_EQ:     cls = CLS_EQ;
      CH_LT:     cls = CLS_LT;
      CH_GT:     cls = CLS_GT;
      CH_LPAREN: cls = CLS_LPAREN;
      CH_RPAREN: cls = CLS_RPAREN;
      CH_SEMI:   cls = CLS_SEMI;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic token_t make_tok(input tok_class_e cls, input logic [7:0] len,
                                      input logic [31:0] val, input logic ovf);
    token_t t;
    t.cls        = cls;
    t.length     = len;
    t.value      = val;
    t.overflowed = ovf;
    t.last       = 1'b0;
    return t;
  endfunction

  function automatic int keyword_index();
    logic [47:0] packed_w;
    string       w;
    if (lx_count > 8'd6 || lx_sat) return -1;
    for (int i = 0; i < 8; i++) begin
      w = kw_text[i];
      packed_w = '0;
      for (int j = 0; j < w.len(); j++) packed_w = {packed_w[39:0], w[j]};
      if (w.len() == lx_count && packed_w == lx_prefix) return i;
    end
    return -1;
  endfunction

  // append one token to the words of the current byte
  task automatic queue_tok(input token_t t);
    step_toks.insert(step_toks.size(), t);
  endtask

  task automatic clear_scan();
    lx_mode   = LX_IDLE;
    lx_prefix = '0;
    lx_count  = '0;
    lx_value  = '0;
    lx_sat    = 1'b0;
  endtask

  task automatic count_char(input logic [7:0] c);
    if (lx_count < LEN_MAX) begin
      if (lx_count < 8'd6) lx_prefix = {lx_prefix[39:0], c};
      lx_count++;
    end else begin
      lx_sat = 1'b1;
    end
  endtask

  task automatic add_digit(input logic [7:0] c);
    logic [63:0] v;
    v = lx_value * 64'd10 + 64'(c - CH_0);
    count_char(c);
    if (v > 64'(VALUE_MAX)) begin
      v = 64'(VALUE_MAX);
      lx_sat = 1'b1;
    end
    lx_value = v;
  endtask

  // emit the pending identifier or number, if any, and go idle
  task automatic close_token();
    int kw;
    if (lx_mode == LX_IDENT) begin
      kw = keyword_index();
      if (kw >= 0) queue_tok(make_tok(CLS_RESERVED, lx_count, 32'(kw), 1'b0));
      else queue_tok(make_tok(CLS_IDENT, lx_count, '0, lx_sat));
    end else if (lx_mode == LX_NUMBER) begin
      queue_tok(make_tok(CLS_NUMBER, lx_count, lx_value[31:0], lx_sat));
    end
    clear_scan();
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic fl);
    tok_class_e cls;
    step_toks.delete();
    if (fl) begin
      close_token();
    end else if (lx_mode == LX_COMMENT) begin
      if (c == CH_RBRACE) lx_mode = LX_IDLE;
    end else if (lx_mode == LX_COLON && c == CH_EQ) begin
      lx_mode = LX_IDLE;
      queue_tok(make_tok(CLS_ASSIGN, 8'd2, '0, 1'b0));
    end else if (lx_mode == LX_IDENT && (is_letter(c) || is_digit(c))) begin
      count_char(c);
    end else if (lx_mode == LX_NUMBER && is_digit(c)) begin
      add_digit(c);
    end else begin
      close_token();
      if (is_letter(c)) begin
        lx_mode = LX_IDENT;
        count_char(c);
      end else if (is_digit(c)) begin
        lx_mode = LX_NUMBER;
        add_digit(c);
      end else if (c == CH_LBRACE) begin
        lx_mode = LX_COMMENT;
      end else if (c == CH_COLON) begin
        lx_mode = LX_COLON;
      end else if (op_class(c, cls)) begin
        queue_tok(make_tok(cls, 8'd1, '0, 1'b0));
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
  endtask

  task automatic check_token();
    token_t want;
    if (token_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected token: class %0d len %0d value %0d ovf %0d last %0d",
                 out_if.token_class, out_if.token_length, out_if.token_value,
                 out_if.overflowed, out_if.last);
      mismatches++;
    end else begin
      want = token_q.pop_front();
      if (out_if.token_class !== want.cls || out_if.token_length !== want.length ||
          out_if.token_value !== want.value || out_if.overflowed !== want.overflowed ||
          out_if.last !== want.last) begin
        if (mismatches < 10) begin
          $display("token mismatch: exp class %0d len %0d value %0d ovf %0d last %0d",
                   want.cls, want.length, want.value, want.overflowed, want.last);
          $display("                got class %0d len %0d value %0d ovf %0d last %0d",
                   out_if.token_class, out_if.token_length, out_if.token_value,
                   out_if.overflowed, out_if.last);
        end
        mismatches++;
      end
    end
  endtask

  // mostly short gaps, some long, none at all while calm
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // ---------------- stimulus building ----------------

  task automatic push_byte(input logic [7:0] c, input logic fl);
    src_byte_t b;
    b.ch    = c;
    b.flush = fl;
    byte_q.insert(byte_q.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return $urandom_range(1) ? CH_LO_A + c : CH_UP_A + c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(3) == 0) return CH_0 + 8'($urandom_range(9));
    return rand_letter();
  endfunction

  task automatic push_ident(input int unsigned n);
    push_byte(rand_letter(), 1'b0);
    for (int unsigned i = 1; i < n; i++) push_byte(rand_alnum(), 1'b0);
  endtask

  task automatic push_number(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic push_sep();
    case ($urandom_range(4))
      0: push_byte(8'h20, 1'b0);
      1: push_byte(8'h0A, 1'b0);
      2: push_byte(8'h09, 1'b0);
      3: push_byte(op_chars[$urandom_range(9)], 1'b0);
      default: ;
    endcase
  endtask

  task automatic push_comment();
    logic [7:0] c;
    push_byte(CH_LBRACE, 1'b0);
    repeat ($urandom_range(10)) begin
      c = 8'($urandom_range(255));
      if (c == CH_RBRACE) c = 8'h0A;
      push_byte(c, 1'b0);
    end
    if ($urandom_range(7) == 0) push_byte(8'($urandom_range(255)), 1'b1);
    else push_byte(CH_RBRACE, 1'b0);
  endtask

  task automatic build_stimulus();
    int unsigned r;
    int unsigned base;
    // directed: keyword before operator, letter after number, all operators,
    // assign, lone colon, multi-line comment, flush in comment and after colon
    push_text("if(");
    push_text("7b+");
    push_text("-*/=<>)");
    push_text(":=;:q");
    push_text("{\n}");
    push_text("{z");
    push_byte(8'h00, 1'b1);
    push_text(":");
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_text("repeatx 99999999999 ");
    // saturating lengths, and the longest length that just fits
    base = byte_q.size();
    push_ident(255);
    push_sep();
    push_byte(8'h20, 1'b0);
    push_ident(262);
    push_byte(8'h0A, 1'b0);
    push_number(258);
    push_byte(8'h00, 1'b1);
    while (byte_q.size() < base + RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 25) begin
        push_ident(($urandom_range(199) == 0) ? $urandom_range(300, 250) : $urandom_range(8, 1));
        push_sep();
      end else if (r < 40) begin
        push_text(kw_text[$urandom_range(7)]);
        if ($urandom_range(4) == 0) push_byte(rand_alnum(), 1'b0);
        push_sep();
      end else if (r < 55) begin
        push_number(($urandom_range(199) == 0) ? $urandom_range(300, 250) : $urandom_range(12, 1));
        push_sep();
      end else if (r < 68) begin
        push_byte(op_chars[$urandom_range(9)], 1'b0);
      end else if (r < 73) begin
        push_text(":=");
      end else if (r < 76) begin
        push_byte(CH_COLON, 1'b0);
      end else if (r < 82) begin
        push_comment();
      end else if (r < 87) begin
        push_sep();
      end else if (r < 94) begin
        push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        push_byte(8'($urandom_range(255)), 1'b1);
      end
    end
    push_byte(8'h00, 1'b1);
    total_bytes = byte_q.size();
  endtask

  // ---------------- driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    int unsigned gap_left;
    int unsigned sent_cnt;
    src_byte_t   nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.ch    <= '0;
      in_if.flush <= 1'b0;
      gap_left = 0;
      sent_cnt = 0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold word until taken
    end else if (gap_left > 0) begin
      in_if.valid <= 1'b0;
      gap_left--;
    end else if (byte_q.size() > 0) begin
      nxt = byte_q.pop_front();
      in_if.valid <= 1'b1;
      in_if.ch    <= nxt.ch;
      in_if.flush <= nxt.flush;
      sent_cnt++;
      gap_left = pick_gap((sent_cnt % 300) < 80);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // ---------------- monitor and scoreboard ----------------

  always @(posedge clk_i or negedge rst_ni) begin : watch_tokens
    int unsigned stall_left;
    int unsigned cyc;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      bytes_taken  <= 0;
      stall_left = 0;
      cyc = 0;
      clear_scan();
    end else begin
      cyc++;
      if (out_if.valid && out_if.ready) check_token();
      if (in_if.valid && in_if.ready) begin
        scan_byte(in_if.ch, in_if.flush);
        bytes_taken <= bytes_taken + 1;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap((cyc % 400) < 100);
      end
    end
  end

  // one long hold-off on the token side so the input backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(bytes_taken == total_bytes && token_q.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
